>>> src/assert_macros.svh
// assertion macros shared by the rotation column sequencer rtl
// expects clk and rst_n to be visible in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define POV_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold in the same cycle as the antecedent
`define POV_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition that must hold in the cycle after the antecedent
`define POV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/pov_pkg.sv
// shared constants and types of the rotation synced column sequencer
// no dependencies; used by pov_store and the top level
`timescale 1ns / 1ps
`default_nettype none

package pov_pkg;

    // image geometry and time base
    localparam int NUM_COLUMNS = 120;
    localparam int TIME_BITS   = 24;
    localparam int COL_W       = $clog2(NUM_COLUMNS);
    localparam int ADDR_W      = 7;
    localparam int COL_DATA_W  = 8;
    localparam int LED_W       = 7;

    // item packing on the stream ports
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // item kinds carried in tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // saturation limit of the time counters
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // column hold time is period / COL_DIVISOR, done as a reciprocal multiply
    localparam int COL_DIVISOR = 120;
    localparam int DIV_SHIFT   = TIME_BITS + $clog2(COL_DIVISOR);
    localparam int RECIP_W     = TIME_BITS + 1;
    localparam int PROD_W      = TIME_BITS + RECIP_W;
    localparam int HOLD_W      = PROD_W - DIV_SHIFT;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << DIV_SHIFT) + COL_DIVISOR - 1) / COL_DIVISOR;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    // start window: period/3 <= t < period*121/360, scaled to integers
    localparam int WIN_W     = TIME_BITS + 9;
    localparam int WIN_LO_MUL = 3;
    localparam int WIN_T_MUL  = 360;
    localparam int WIN_P_MUL  = 121;

    // write port of the image store
    typedef struct packed {
        logic                  en;
        logic [COL_W-1:0]      addr;
        logic [COL_DATA_W-1:0] data;
    } store_wr_t;

endpackage

`default_nettype wire

>>> src/pov_store.sv
// image column store: one write port, one registered read port
// depends on pov_pkg for geometry and the write port struct
`timescale 1ns / 1ps
`default_nettype none

module pov_store
    import pov_pkg::*;
(
    input  wire logic                  clk,
    input  wire store_wr_t             wr,
    input  wire logic                  rd_en,
    input  wire logic [COL_W-1:0]      rd_addr,
    output logic      [COL_DATA_W-1:0] rd_data
);

    logic [COL_DATA_W-1:0] image_mem [NUM_COLUMNS];
    logic [COL_DATA_W-1:0] rd_data_reg;

    // column writes
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            image_mem[wr.addr] <= wr.data;
        end
    end

    // registered read, holds while no item is taken
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= image_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/pov_rotation_synced_column_sequencer_unit.sv
// a result item is registered and presented in the cycle after its input item is taken
// throughput: one item per cycle; input ready while the output register is empty or taken
// the image store has a registered read, a write to the column shown is forwarded
// reset (rst_n low, async) clears the counters, period, sweep state and output valid
// the image store is not cleared; a column reads as written once it has been written
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pov_rotation_synced_column_sequencer_unit
    import pov_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [0] index_pulse, [7:1] column_addr, [15:8] column_data
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // [0] func
    input  wire logic [0:0]          s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [6:0] led_pattern, [7] showing, [8] timing_valid, [15:9] zero
    output logic      [M_DATA_W-1:0] m_axis_tdata
);

    // unpacked input fields
    logic                  func;
    logic                  index_pulse;
    logic [ADDR_W-1:0]     column_addr;
    logic [COL_DATA_W-1:0] column_data;

    assign func        = s_axis_tuser[0];
    assign index_pulse = s_axis_tdata[0];
    assign column_addr = s_axis_tdata[7:1];
    assign column_data = s_axis_tdata[15:8];

    // control state
    logic [TIME_BITS-1:0] since_pulse_reg, since_pulse_next;
    logic [TIME_BITS-1:0] since_origin_reg, since_origin_next;
    logic [TIME_BITS-1:0] period_reg, period_next;
    logic                 pulse_seen_reg, pulse_seen_next;
    logic                 period_known_reg, period_known_next;
    logic                 done_reg, done_next;
    logic                 active_reg, active_next;
    logic [COL_W-1:0]     column_index_reg, column_index_next;
    logic [HOLD_W-1:0]    hold_left_reg, hold_left_next;

    // output stage
    logic                  out_valid_reg, out_valid_next;
    logic                  out_show_reg, out_show_next;
    logic                  out_tv_reg, out_tv_next;
    logic                  out_fwd_reg, out_fwd_next;
    logic [COL_DATA_W-1:0] out_fwd_data_reg;

    // datapath
    logic                  in_acc;
    logic                  tick_acc;
    logic [TIME_BITS-1:0]  since_pulse_inc;
    logic [TIME_BITS-1:0]  since_origin_inc;
    logic [TIME_BITS-1:0]  since_origin_upd;
    logic [TIME_BITS-1:0]  period_upd;
    logic                  period_known_upd;
    logic                  done_upd;
    logic [PROD_W-1:0]     recip_prod;
    logic [HOLD_W-1:0]     quot;
    logic [HOLD_W-1:0]     col_ticks;
    logic                  win_lo;
    logic                  win_hi;
    logic                  start;
    logic                  act;
    logic [COL_W-1:0]      col_cur;
    logic [HOLD_W-1:0]     hold_cur;
    logic [HOLD_W-1:0]     hold_dec;
    logic [COL_W-1:0]      rd_addr;
    store_wr_t             store_wr;
    logic [COL_DATA_W-1:0] store_q;
    logic [COL_DATA_W-1:0] col_bits;
    logic [LED_W-1:0]      led_pattern;

    // handshake
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign tick_acc      = in_acc && (func == FUNC_TICK);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // saturating time counters and pulse handling
    always_comb
    begin
        since_pulse_inc  = (since_pulse_reg == TIME_MAX) ? since_pulse_reg
                                                         : since_pulse_reg + 1'b1;
        since_origin_inc = (since_origin_reg == TIME_MAX) ? since_origin_reg
                                                          : since_origin_reg + 1'b1;
        since_origin_upd = index_pulse ? '0 : since_origin_inc;
        period_upd       = (index_pulse && pulse_seen_reg) ? since_pulse_inc : period_reg;
        period_known_upd = period_known_reg || (index_pulse && pulse_seen_reg);
        done_upd         = index_pulse ? 1'b0 : done_reg;
    end

    // column hold time, floor(period / 120) and at least one tick
    always_comb
    begin
        recip_prod = PROD_W'(period_upd) * PROD_W'(RECIP);
        quot       = recip_prod[PROD_W-1:DIV_SHIFT];
        col_ticks  = (quot == '0) ? HOLD_W'(1) : quot;
    end

    // start window check in exact integers
    always_comb
    begin
        win_lo = (WIN_W'(since_origin_upd) * WIN_W'(WIN_LO_MUL)) >= WIN_W'(period_upd);
        win_hi = (WIN_W'(since_origin_upd) * WIN_W'(WIN_T_MUL))
                 < (WIN_W'(period_upd) * WIN_W'(WIN_P_MUL));
        start  = !active_reg && !done_upd && period_known_upd && win_lo && win_hi;
    end

    // sweep sequencing and next state
    always_comb
    begin
        act      = active_reg || start;
        col_cur  = start ? '0 : column_index_reg;
        hold_cur = start ? col_ticks : hold_left_reg;
        hold_dec = (hold_cur != '0) ? hold_cur - 1'b1 : hold_cur;

        since_pulse_next  = since_pulse_reg;
        since_origin_next = since_origin_reg;
        period_next       = period_reg;
        pulse_seen_next   = pulse_seen_reg;
        period_known_next = period_known_reg;
        done_next         = done_reg;
        active_next       = active_reg;
        column_index_next = column_index_reg;
        hold_left_next    = hold_left_reg;

        if (tick_acc)
        begin
            since_pulse_next  = index_pulse ? '0 : since_pulse_inc;
            since_origin_next = since_origin_upd;
            period_next       = period_upd;
            pulse_seen_next   = pulse_seen_reg || index_pulse;
            period_known_next = period_known_upd;
            done_next         = done_upd || start;
            active_next       = act;
            column_index_next = col_cur;
            hold_left_next    = hold_cur;
            if (act)
            begin
                hold_left_next = hold_dec;
                if (hold_dec == '0)
                begin
                    if (col_cur == COL_W'(NUM_COLUMNS - 1))
                    begin
                        active_next       = 1'b0;
                        column_index_next = '0;
                    end
                    else
                    begin
                        column_index_next = col_cur + 1'b1;
                        hold_left_next    = col_ticks;
                    end
                end
            end
        end
    end

    // store access: write item lands now, the shown column is read alongside
    always_comb
    begin
        store_wr.en   = in_acc && (func == FUNC_WRITE)
                        && ({1'b0, column_addr} < (ADDR_W + 1)'(NUM_COLUMNS));
        store_wr.addr = COL_W'(column_addr);
        store_wr.data = column_data;
        rd_addr       = tick_acc ? col_cur : column_index_reg;
    end

    pov_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (in_acc),
        .rd_addr (rd_addr),
        .rd_data (store_q)
    );

    // output stage next values
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_show_next  = out_show_reg;
        out_tv_next    = out_tv_reg;
        out_fwd_next   = out_fwd_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            out_show_next  = tick_acc ? act : active_reg;
            out_tv_next    = tick_acc ? period_known_upd : period_known_reg;
            out_fwd_next   = store_wr.en && (store_wr.addr == column_index_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_pulse_reg  <= '0;
            since_origin_reg <= '0;
            period_reg       <= '0;
            pulse_seen_reg   <= 1'b0;
            period_known_reg <= 1'b0;
            done_reg         <= 1'b0;
            active_reg       <= 1'b0;
            column_index_reg <= '0;
            hold_left_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_show_reg     <= 1'b0;
            out_tv_reg       <= 1'b0;
            out_fwd_reg      <= 1'b0;
        end
        else
        begin
            since_pulse_reg  <= since_pulse_next;
            since_origin_reg <= since_origin_next;
            period_reg       <= period_next;
            pulse_seen_reg   <= pulse_seen_next;
            period_known_reg <= period_known_next;
            done_reg         <= done_next;
            active_reg       <= active_next;
            column_index_reg <= column_index_next;
            hold_left_reg    <= hold_left_next;
            out_valid_reg    <= out_valid_next;
            out_show_reg     <= out_show_next;
            out_tv_reg       <= out_tv_next;
            out_fwd_reg      <= out_fwd_next;
        end
    end

    // forwarded column data, payload only
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_fwd_data_reg <= column_data;
        end
    end

    // led drive: column bits 7..1 reversed onto led 0..6
    always_comb
    begin
        col_bits = out_fwd_reg ? out_fwd_data_reg : store_q;
        for (int k = 0; k < LED_W; k++)
        begin
            led_pattern[k] = out_show_reg && col_bits[LED_W - k];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_DATA_W - LED_W - 2)'(0), out_tv_reg, out_show_reg, led_pattern};

    // checks on the sweep and output logic
    `POV_ASSERT_IMPLIES(a_show_needs_period, out_valid_reg && out_show_reg, out_tv_reg,
        "columns shown without a measured period")
    `POV_ASSERT_IMPLIES(a_active_hold, active_reg, hold_left_reg != '0,
        "sweep running with no hold time left")
    `POV_ASSERT_IMPLIES(a_idle_column, !active_reg, column_index_reg == '0,
        "column index not parked while idle")
    `POV_ASSERT_NEXT(a_period_sticky, period_known_reg, period_known_reg,
        "measured period lost")

endmodule

`default_nettype wire

>>> tb/sv/tb_pov_rotation_synced_column_sequencer_unit.sv
// self-checking bench for the rotation synced column sequencer: tick and image write items
// go in on the slave stream, led results are checked against an in-bench sweep predictor
// depends on pov_pkg and pov_rotation_synced_column_sequencer_unit
`timescale 1ns / 1ps

module tb_pov_rotation_synced_column_sequencer_unit;
    import pov_pkg::*;

    // cycles with no item moving on either side before the run is called hung;
    // worst correct case is one source gap plus one sink stall
    localparam int unsigned WATCHDOG_LIMIT = 400;
    localparam int unsigned RANDOM_ITEMS   = 700;
    localparam longint unsigned TICK_LIMIT = (64'd1 << TIME_BITS) - 1;

    // one input item as queued for the driver
    typedef struct packed {
        logic                  func;
        logic                  pulse;
        logic [ADDR_W-1:0]     addr;
        logic [COL_DATA_W-1:0] data;
    } rotor_item_t;

    // result fields, ordered as they sit in m_axis_tdata[8:0]
    typedef struct packed {
        logic             timing_valid;
        logic             showing;
        logic [LED_W-1:0] led;
    } led_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    rotor_item_t pending_rotor_items[$];
    led_result_t expected_led_results[$];

    int unsigned src_wait = 0;
    int unsigned src_calm = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_calm = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;

    // predictor state, all zero out of reset
    longint unsigned       ticks_since_index = 0;
    longint unsigned       period_ticks = 0;
    longint unsigned       ticks_since_origin = 0;
    longint unsigned       hold_ticks = 0;
    bit                    index_seen = 1'b0;
    bit                    period_valid = 1'b0;
    bit                    swept_this_origin = 1'b0;
    bit                    sweep_on = 1'b0;
    int unsigned           col_now = 0;
    logic [COL_DATA_W-1:0] image_mirror [NUM_COLUMNS];

    pov_rotation_synced_column_sequencer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // column bit 7-k drives led k, bit 0 unused
    function automatic logic [LED_W-1:0] led_drive(input logic [COL_DATA_W-1:0] col);
        logic [LED_W-1:0] r;
        for (int k = 0; k < LED_W; k++)
        begin
            r[k] = col[7 - k];
        end
        return r;
    endfunction

    function automatic longint unsigned sat_tick(input longint unsigned v);
        return (v >= TICK_LIMIT) ? TICK_LIMIT : v + 1;
    endfunction

    // ticks per column, at least one for short periods
    function automatic longint unsigned column_hold();
        longint unsigned d;
        d = period_ticks / 120;
        return (d == 0) ? 1 : d;
    endfunction

    // advance the predictor by one accepted item and return its result
    function automatic led_result_t predict_led(input logic func, input logic pulse,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [COL_DATA_W-1:0] data);
        led_result_t res;
        res = '0;
        if (func == FUNC_WRITE)
        begin
            // writes take no time; the shown column is read after the write lands
            if (addr < NUM_COLUMNS)
                image_mirror[addr] = data;
            res.led     = sweep_on ? led_drive(image_mirror[col_now]) : '0;
            res.showing = sweep_on;
        end
        else
        begin
            ticks_since_index  = sat_tick(ticks_since_index);
            ticks_since_origin = sat_tick(ticks_since_origin);
            // index pulse: measure period, restart origin
            if (pulse)
            begin
                if (index_seen)
                begin
                    period_ticks = ticks_since_index;
                    period_valid = 1'b1;
                end
                index_seen         = 1'b1;
                ticks_since_index  = 0;
                ticks_since_origin = 0;
                swept_this_origin  = 1'b0;
            end
            // sweep start in the 120..121 degree window, once per origin
            if (!sweep_on && !swept_this_origin && period_valid &&
                ticks_since_origin * 3 >= period_ticks &&
                ticks_since_origin * 360 < period_ticks * 121)
            begin
                sweep_on          = 1'b1;
                swept_this_origin = 1'b1;
                col_now           = 0;
                hold_ticks        = column_hold();
            end
            // show current column and step through the image
            if (sweep_on)
            begin
                res.showing = 1'b1;
                res.led     = led_drive(image_mirror[col_now]);
                if (hold_ticks > 0)
                    hold_ticks--;
                if (hold_ticks == 0)
                begin
                    col_now++;
                    if (col_now >= NUM_COLUMNS)
                    begin
                        sweep_on = 1'b0;
                        col_now  = 0;
                    end
                    else
                        hold_ticks = column_hold();
                end
            end
        end
        res.timing_valid = period_valid;
        return res;
    endfunction

    // random per-item wait, with occasional stretches of no waiting at all
    function automatic int unsigned draw_pause(inout int unsigned calm_left);
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    task automatic push_tick(input logic pulse);
        rotor_item_t it;
        it.func  = FUNC_TICK;
        it.pulse = pulse;
        it.addr  = ADDR_W'($urandom_range(0, 127));
        it.data  = COL_DATA_W'($urandom_range(0, 255));
        pending_rotor_items.push_back(it);
    endtask

    task automatic push_write(input int unsigned addr, input logic [COL_DATA_W-1:0] data,
                              input logic pulse);
        rotor_item_t it;
        it.func  = FUNC_WRITE;
        it.pulse = pulse;
        it.addr  = ADDR_W'(addr);
        it.data  = data;
        pending_rotor_items.push_back(it);
    endtask

    // source side: predict on acceptance, then present the next queued item
    always @(posedge clk)
    begin : source_driver
        rotor_item_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_led_results.push_back(predict_led(s_axis_tuser[0], s_axis_tdata[0],
                                                           s_axis_tdata[7:1],
                                                           s_axis_tdata[15:8]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_wait != 0)
                begin
                    src_wait      <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_rotor_items.size() != 0)
                begin
                    nxt = pending_rotor_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.func;
                    s_axis_tdata  <= {nxt.data, nxt.addr, nxt.pulse};
                    src_wait      <= draw_pause(src_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side: check each result item against the oldest prediction, then stall at random
    always @(posedge clk)
    begin : result_monitor
        led_result_t got;
        led_result_t want;
        int unsigned hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            got  = led_result_t'(m_axis_tdata[8:0]);
            hold = sink_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_led_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: led %h showing %b timing %b",
                                 got.led, got.showing, got.timing_valid);
                end
                else
                begin
                    want = expected_led_results.pop_front();
                    if (got.led !== want.led || got.showing !== want.showing ||
                        got.timing_valid !== want.timing_valid)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("mismatch at %0t: expected led %h showing %b timing %b,",
                                   $realtime, want.led, want.showing, want.timing_valid);
                            $display(" got led %h showing %b timing %b",
                                     got.led, got.showing, got.timing_valid);
                        end
                    end
                end
                hold = draw_pause(sink_calm);
            end
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait     <= hold - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_wait     <= 0;
            end
        end
    end

    // watchdog on cycles where no item moves
    always @(posedge clk)
    begin : hang_watchdog
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_pov_rotation_synced_column_sequencer_unit: done, errors");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus_and_end
        int unsigned lap_len;
        int unsigned laps;
        int unsigned pick;
        int unsigned stop_at;
        logic [COL_DATA_W-1:0] fill;

        // fill the whole image before any sweep can start
        for (int c = 0; c < NUM_COLUMNS; c++)
        begin
            case (c)
                0:       fill = 8'hFF;
                1:       fill = 8'h00;
                2:       fill = 8'h01;
                3:       fill = 8'h80;
                4:       fill = 8'hFE;
                default: fill = COL_DATA_W'($urandom_range(0, 255));
            endcase
            push_write(c, fill, 1'($urandom_range(0, 1)));
        end

        // directed: out of range writes, no-period ticks, back to back pulses,
        // shortest period with a sweep, write to the shown column, pulse mid sweep
        push_write(120, 8'hFF, 1'b0);
        push_write(127, 8'hFF, 1'b1);
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b0);
        push_write(1, 8'hA5, 1'b0);
        push_tick(1'b0);
        push_tick(1'b1);
        push_write(0, 8'h5A, 1'b1);
        repeat (7) push_tick(1'b0);
        push_write(119, 8'h81, 1'b0);
        push_write(127, 8'h00, 1'b0);

        // random: runs of laps at one period, with writes and stray pulses mixed in
        stop_at = pending_rotor_items.size() + RANDOM_ITEMS;
        while (pending_rotor_items.size() < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                lap_len = $urandom_range(1, 8);
            else if (pick < 45)
                lap_len = $urandom_range(9, 80);
            else if (pick < 85)
                lap_len = $urandom_range(81, 239);
            else
                lap_len = $urandom_range(240, 400);
            laps = (lap_len > 200) ? 2 : $urandom_range(2, 4);
            repeat (laps)
            begin
                for (int i = 0; (i < lap_len) && (pending_rotor_items.size() < stop_at); i++)
                begin
                    push_tick((i == 0) || ($urandom_range(0, 99) < 2));
                    if ($urandom_range(0, 99) < 8)
                        push_write(($urandom_range(0, 99) < 85) ? $urandom_range(0, 119)
                                                                : $urandom_range(120, 127),
                                   COL_DATA_W'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)));
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // drain, then wait for any stray result item
        while (pending_rotor_items.size() != 0 || s_axis_tvalid ||
               expected_led_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_pov_rotation_synced_column_sequencer_unit: done, clean");
        else
            $display("tb_pov_rotation_synced_column_sequencer_unit: done, errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/pov_pkg.sv
src/pov_store.sv
src/pov_rotation_synced_column_sequencer_unit.sv
tb/sv/tb_pov_rotation_synced_column_sequencer_unit.sv
